// ----- hw/rtl/lrc_pkg.sv -----
// Shared widths and constants for the line/ray/segment rectangle clipper.
// Used by lrc_scale and line_ray_segment_rect_clip; no dependencies.
package lrc_pkg;

  localparam int CW          = 32;   // port coordinate width, Q16.16
  localparam int BW          = 34;   // box coordinate width
  localparam int PW          = 50;   // intermediate point width, saturates at +-2^48
  localparam int N1W         = 35;   // scale operand widths
  localparam int N2W         = 51;
  localparam int DW          = 51;
  localparam int PRW         = N1W + N2W;
  localparam int QW          = 49;   // quotient bits
  localparam int MUL_SPLIT   = 26;   // low slice of the scale multiplier
  localparam int H_SPLIT     = 17;   // low slice of the dominance multiplier
  localparam int DOM_PPW     = CW + 1 + H_SPLIT;
  localparam int DOM_W       = CW + 1 + BW;
  localparam int SCL_LAT     = QW + 5;
  localparam int EPSILON_LSB = 1;

  localparam logic signed [BW-1:0] EPS_B = BW'(EPSILON_LSB);
  localparam logic signed [PW-1:0] EPS_P = PW'(EPSILON_LSB);
  localparam logic signed [PW-1:0] LIM48 = 50'sh1_0000_0000_0000;

endpackage

// ----- hw/rtl/lrc_scale.sv -----
// Pipelined trunc(n1 * n2 / d) with saturation to +-2^48.
// Depends on lrc_pkg; restoring divider, one quotient bit per stage.
module lrc_scale
  import lrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [N1W-1:0] n1,
  input  logic signed [N2W-1:0] n2,
  input  logic signed [DW-1:0]  d,
  output logic signed [PW-1:0]  q
);

  logic [N1W-1:0] a_m1_r, a_m1_nxt;
  logic [N2W-1:0] a_m2_r, a_m2_nxt;
  logic [DW-1:0]  a_md_r, a_md_nxt;
  logic           a_neg_r;

  logic [N1W+MUL_SPLIT-1:0]       b_pl_r;
  logic [N1W+N2W-MUL_SPLIT-1:0]   b_ph_r;
  logic [DW-1:0]                  b_md_r;
  logic                           b_neg_r;

  logic [PRW-1:0] c_prod_r, c_prod_nxt;
  logic [DW-1:0]  c_md_r;
  logic           c_neg_r;

  logic [DW-1:0] dv_rem_r [QW+1];
  logic [DW-1:0] dv_md_r  [QW+1];
  logic [QW-1:0] dv_lo_r  [QW+1];
  logic [QW-1:0] dv_q_r   [QW+1];
  logic          dv_sat_r [QW+1];
  logic          dv_neg_r [QW+1];

  logic signed [PW-1:0] qm, qmag, q_nxt, q_r;

  always_comb begin
    a_m1_nxt = n1[N1W-1] ? N1W'(-n1) : N1W'(n1);
    a_m2_nxt = n2[N2W-1] ? N2W'(-n2) : N2W'(n2);
    a_md_nxt = d[DW-1]   ? DW'(-d)   : DW'(d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m1_r  <= a_m1_nxt;
      a_m2_r  <= a_m2_nxt;
      a_md_r  <= a_md_nxt;
      a_neg_r <= n1[N1W-1] ^ n2[N2W-1] ^ d[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pl_r  <= (N1W+MUL_SPLIT)'(a_m1_r) * (N1W+MUL_SPLIT)'(a_m2_r[MUL_SPLIT-1:0]);
      b_ph_r  <= (N1W+N2W-MUL_SPLIT)'(a_m1_r) *
                 (N1W+N2W-MUL_SPLIT)'(a_m2_r[N2W-1:MUL_SPLIT]);
      b_md_r  <= a_md_r;
      b_neg_r <= a_neg_r;
    end
  end

  assign c_prod_nxt = PRW'(b_pl_r) + (PRW'(b_ph_r) << MUL_SPLIT);

  always_ff @(posedge clk) begin
    if (en) begin
      c_prod_r <= c_prod_nxt;
      c_md_r   <= b_md_r;
      c_neg_r  <= b_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= DW'(c_prod_r[PRW-1:QW]);
      dv_sat_r[0] <= DW'(c_prod_r[PRW-1:QW]) >= c_md_r;
      dv_lo_r[0]  <= c_prod_r[QW-1:0];
      dv_md_r[0]  <= c_md_r;
      dv_q_r[0]   <= '0;
      dv_neg_r[0] <= c_neg_r;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {dv_rem_r[k], dv_lo_r[k][QW-1-k]};
      ge    = trial >= {1'b0, dv_md_r[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= ge ? DW'(trial - {1'b0, dv_md_r[k]}) : DW'(trial);
        dv_q_r[k+1]   <= {dv_q_r[k][QW-2:0], ge};
        dv_lo_r[k+1]  <= dv_lo_r[k];
        dv_md_r[k+1]  <= dv_md_r[k];
        dv_sat_r[k+1] <= dv_sat_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
      end
    end
  end

  always_comb begin
    qm    = PW'(dv_q_r[QW]);
    qmag  = (dv_sat_r[QW] || qm > LIM48) ? LIM48 : qm;
    q_nxt = dv_neg_r[QW] ? -qmag : qmag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- hw/rtl/line_ray_segment_rect_clip.sv -----
// Line, ray and segment clipper against a configured rectangle, Q16.16.
// Throughput: one transaction per cycle while not stalled; the 49-stage restoring
// dividers inside the two pairs of lrc_scale units set the depth. Stalls freeze the
// whole pipeline.
// Reset (synchronous, rst_n low): clears all valid bits and loads the
// rectangle registers with -1.0 / -1.0 / 1.0 / 1.0.
module line_ray_segment_rect_clip
  import lrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic signed [CW-1:0] in_start_x,
  input  logic signed [CW-1:0] in_start_y,
  input  logic signed [CW-1:0] in_end_x,
  input  logic signed [CW-1:0] in_end_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_visible,
  output logic signed [CW-1:0] out_clip_start_x,
  output logic signed [CW-1:0] out_clip_start_y,
  output logic signed [CW-1:0] out_clip_end_x,
  output logic signed [CW-1:0] out_clip_end_y
);

  typedef enum logic [1:0] {OP_LINE, OP_RAY, OP_SEG} op_e;
  typedef enum logic [1:0] {REG_LEFT, REG_BOTTOM, REG_RIGHT, REG_TOP} reg_e;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, ex, ey;
    logic signed [BW-1:0] x0, y0, x1, y1;
  } geo_t;

  typedef struct packed {
    logic                 ok;
    logic                 xdom;
    logic signed [BW-1:0] a0, a1;
    logic signed [CW-1:0] b0, b1;
    logic signed [BW-1:0] clo, chi;
  } str_side_t;

  typedef struct packed {
    logic                 ok;
    logic                 xdom;
    logic signed [PW-1:0] a0, a1;
    logic signed [BW-1:0] b0, b1;
    logic                 mv0, mv1;
    logic signed [BW-1:0] t0, t1;
  } cut_side_t;

  function automatic logic signed [PW-1:0] sat48(input logic signed [PW:0] v);
    if (v > (PW+1)'(LIM48)) return LIM48;
    else if (v < -(PW+1)'(LIM48)) return -LIM48;
    else return PW'(v);
  endfunction

  function automatic logic signed [CW-1:0] sat32(input logic signed [PW-1:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else return CW'(v);
  endfunction

  logic adv;

  logic signed [CW-1:0] rect_left_r, rect_bottom_r, rect_right_r, rect_top_r;

  // stage valid bits
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic s9_v_r, s10_v_r, s11_v_r, out_valid_r;
  logic [SCL_LAT-1:0] dl1_v_r, dl2_v_r;

  // stage 1
  logic [1:0]           s1_op_r;
  logic signed [CW-1:0] s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;

  // stage 2
  logic signed [BW-1:0] p_sx, p_sy, p_ex, p_ey, rl, rb, rr, rt;
  logic signed [BW-1:0] lx, ly, hx, hy;
  geo_t s2_g_nxt, s2_g_r;
  logic s2_ok_nxt, s2_ok_r;

  // stage 3
  logic                  box_empty;
  geo_t                  s3_g_r;
  logic                  s3_ok_r;
  logic [BW-1:0]         s3_w_r, s3_h_r;
  logic signed [CW:0]    s3_dx_r, s3_dy_r;

  // stage 4
  geo_t          s4_g_r;
  logic          s4_ok_r;
  logic [BW-1:0] s4_w_r, s4_h_r;
  logic [CW:0]   s4_adx_r, s4_ady_r;

  // stage 5
  geo_t               s5_g_r;
  logic               s5_ok_r;
  logic [DOM_PPW-1:0] s5_pxl_r, s5_pxh_r, s5_pyl_r, s5_pyh_r;

  // stage 6
  geo_t             s6_g_r;
  logic             s6_ok_r;
  logic [DOM_W-1:0] s6_px_r, s6_py_r;

  // stage 7
  logic                 s7_xdom_nxt;
  logic                 s7_ok_r, s7_xdom_r;
  logic signed [CW-1:0] s7_a0_r, s7_a1_r, s7_b0_r, s7_b1_r;
  logic signed [CW-1:0] s7_a0_nxt, s7_a1_nxt, s7_b0_nxt, s7_b1_nxt;
  logic signed [BW-1:0] s7_lo_r, s7_hi_r, s7_clo_r, s7_chi_r;
  logic signed [BW-1:0] s7_lo_nxt, s7_hi_nxt, s7_clo_nxt, s7_chi_nxt;

  // stage 8
  logic                 s8_dir, s8_tiny;
  logic signed [BW-1:0] s8_a0b, s8_a1b;
  logic signed [CW:0]   s8_da_r, s8_db_r;
  logic signed [BW:0]   s8_n20_r, s8_n21_r, s8_n20_nxt, s8_n21_nxt;
  str_side_t            s8_side_nxt, s8_side_r;

  str_side_t dl1_r [SCL_LAT];
  logic signed [PW-1:0] q0, q1, q2, q3;

  // stage 9
  str_side_t            s9_side_r;
  logic signed [PW-1:0] s9_b0_r, s9_b1_r;

  // stage 10
  logic signed [PW-1:0] c_lo, c_hi, c_a0, c_a1;
  logic                 c_rej, c_dir, c_tiny;
  logic signed [PW:0]   s10_da_r, s10_n20_r, s10_n21_r, s10_n20_nxt, s10_n21_nxt;
  logic signed [BW:0]   s10_db_r;
  cut_side_t            s10_side_nxt, s10_side_r;

  cut_side_t dl2_r [SCL_LAT];
  cut_side_t dl2_o;

  // stage 11
  logic signed [PW-1:0] c_a0n, c_a1n, c_b0n, c_b1n;
  logic                 s11_ok_r;
  logic signed [PW-1:0] s11_x0_r, s11_y0_r, s11_x1_r, s11_y1_r;

  // output register
  logic                 out_visible_r;
  logic signed [CW-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= -32'sd65536;
      rect_bottom_r <= -32'sd65536;
      rect_right_r  <= 32'sd65536;
      rect_top_r    <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (reg_e'(cfg_index))
        REG_LEFT:   rect_left_r   <= cfg_data;
        REG_BOTTOM: rect_bottom_r <= cfg_data;
        REG_RIGHT:  rect_right_r  <= cfg_data;
        REG_TOP:    rect_top_r    <= cfg_data;
        default:    rect_top_r    <= rect_top_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      dl1_v_r     <= '0;
      s9_v_r      <= 1'b0;
      s10_v_r     <= 1'b0;
      dl2_v_r     <= '0;
      s11_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= s6_v_r;
      s8_v_r      <= s7_v_r;
      dl1_v_r     <= {dl1_v_r[SCL_LAT-2:0], s8_v_r};
      s9_v_r      <= dl1_v_r[SCL_LAT-1];
      s10_v_r     <= s9_v_r;
      dl2_v_r     <= {dl2_v_r[SCL_LAT-2:0], s10_v_r};
      s11_v_r     <= dl2_v_r[SCL_LAT-1];
      out_valid_r <= s11_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= in_op;
      s1_sx_r <= in_start_x;
      s1_sy_r <= in_start_y;
      s1_ex_r <= in_end_x;
      s1_ey_r <= in_end_y;
    end
  end

  always_comb begin
    p_sx = BW'(s1_sx_r);
    p_sy = BW'(s1_sy_r);
    p_ex = BW'(s1_ex_r);
    p_ey = BW'(s1_ey_r);
    rl   = BW'(rect_left_r);
    rb   = BW'(rect_bottom_r);
    rr   = BW'(rect_right_r);
    rt   = BW'(rect_top_r);
    lx   = ((p_sx < p_ex) ? p_sx : p_ex) - EPS_B;
    ly   = ((p_sy < p_ey) ? p_sy : p_ey) - EPS_B;
    hx   = ((p_sx > p_ex) ? p_sx : p_ex) + EPS_B;
    hy   = ((p_sy > p_ey) ? p_sy : p_ey) + EPS_B;
    s2_g_nxt    = '{sx: s1_sx_r, sy: s1_sy_r, ex: s1_ex_r, ey: s1_ey_r,
                    x0: rl, y0: rb, x1: rr, y1: rt};
    s2_ok_nxt   = 1'b1;
    unique case (op_e'(s1_op_r))
      OP_LINE: s2_ok_nxt = 1'b1;
      OP_RAY: begin
        if (p_sx <= p_ex) begin
          if (rl < p_sx - EPS_B) s2_g_nxt.x0 = p_sx - EPS_B;
        end else if (rr > p_sx + EPS_B) begin
          s2_g_nxt.x1 = p_sx + EPS_B;
        end
        if (p_sy <= p_ey) begin
          if (rb < p_sy - EPS_B) s2_g_nxt.y0 = p_sy - EPS_B;
        end else if (rt > p_sy + EPS_B) begin
          s2_g_nxt.y1 = p_sy + EPS_B;
        end
      end
      OP_SEG: begin
        s2_g_nxt.x0 = (lx > rl) ? lx : rl;
        s2_g_nxt.y0 = (ly > rb) ? ly : rb;
        s2_g_nxt.x1 = (hx < rr) ? hx : rr;
        s2_g_nxt.y1 = (hy < rt) ? hy : rt;
      end
      default: s2_ok_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_g_r  <= s2_g_nxt;
      s2_ok_r <= s2_ok_nxt;
    end
  end

  assign box_empty = (s2_g_r.x0 == s2_g_r.x1 && s2_g_r.y0 == s2_g_r.y1) ||
                     s2_g_r.x0 > s2_g_r.x1 || s2_g_r.y0 > s2_g_r.y1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_g_r  <= s2_g_r;
      s3_ok_r <= s2_ok_r && !box_empty;
      s3_w_r  <= BW'(s2_g_r.x1 - s2_g_r.x0);
      s3_h_r  <= BW'(s2_g_r.y1 - s2_g_r.y0);
      s3_dx_r <= (CW+1)'(s2_g_r.sx) - (CW+1)'(s2_g_r.ex);
      s3_dy_r <= (CW+1)'(s2_g_r.sy) - (CW+1)'(s2_g_r.ey);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_g_r   <= s3_g_r;
      s4_ok_r  <= s3_ok_r;
      s4_w_r   <= s3_w_r;
      s4_h_r   <= s3_h_r;
      s4_adx_r <= s3_dx_r[CW] ? (CW+1)'(-s3_dx_r) : (CW+1)'(s3_dx_r);
      s4_ady_r <= s3_dy_r[CW] ? (CW+1)'(-s3_dy_r) : (CW+1)'(s3_dy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_g_r   <= s4_g_r;
      s5_ok_r  <= s4_ok_r;
      s5_pxl_r <= DOM_PPW'(s4_adx_r) * DOM_PPW'(s4_h_r[H_SPLIT-1:0]);
      s5_pxh_r <= DOM_PPW'(s4_adx_r) * DOM_PPW'(s4_h_r[BW-1:H_SPLIT]);
      s5_pyl_r <= DOM_PPW'(s4_ady_r) * DOM_PPW'(s4_w_r[H_SPLIT-1:0]);
      s5_pyh_r <= DOM_PPW'(s4_ady_r) * DOM_PPW'(s4_w_r[BW-1:H_SPLIT]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_g_r  <= s5_g_r;
      s6_ok_r <= s5_ok_r;
      s6_px_r <= DOM_W'(s5_pxl_r) + (DOM_W'(s5_pxh_r) << H_SPLIT);
      s6_py_r <= DOM_W'(s5_pyl_r) + (DOM_W'(s5_pyh_r) << H_SPLIT);
    end
  end

  always_comb begin
    s7_xdom_nxt = s6_px_r > s6_py_r;
    if (s7_xdom_nxt) begin
      s7_a0_nxt  = s6_g_r.sx;
      s7_a1_nxt  = s6_g_r.ex;
      s7_b0_nxt  = s6_g_r.sy;
      s7_b1_nxt  = s6_g_r.ey;
      s7_lo_nxt  = s6_g_r.x0;
      s7_hi_nxt  = s6_g_r.x1;
      s7_clo_nxt = s6_g_r.y0;
      s7_chi_nxt = s6_g_r.y1;
    end else begin
      s7_a0_nxt  = s6_g_r.sy;
      s7_a1_nxt  = s6_g_r.ey;
      s7_b0_nxt  = s6_g_r.sx;
      s7_b1_nxt  = s6_g_r.ex;
      s7_lo_nxt  = s6_g_r.y0;
      s7_hi_nxt  = s6_g_r.y1;
      s7_clo_nxt = s6_g_r.x0;
      s7_chi_nxt = s6_g_r.x1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ok_r   <= s6_ok_r;
      s7_xdom_r <= s7_xdom_nxt;
      s7_a0_r   <= s7_a0_nxt;
      s7_a1_r   <= s7_a1_nxt;
      s7_b0_r   <= s7_b0_nxt;
      s7_b1_r   <= s7_b1_nxt;
      s7_lo_r   <= s7_lo_nxt;
      s7_hi_r   <= s7_hi_nxt;
      s7_clo_r  <= s7_clo_nxt;
      s7_chi_r  <= s7_chi_nxt;
    end
  end

  always_comb begin
    s8_a0b  = BW'(s7_a0_r);
    s8_a1b  = BW'(s7_a1_r);
    s8_dir  = s7_a1_r > s7_a0_r;
    s8_tiny = (s8_a1b == s8_a0b) ||
              ((s8_a1b < s8_a0b + EPS_B) && (s8_a1b > s8_a0b - EPS_B));
    s8_n20_nxt = (BW+1)'(s8_dir ? s7_lo_r : s7_hi_r) - (BW+1)'(s7_a0_r);
    s8_n21_nxt = (BW+1)'(s8_dir ? s7_hi_r : s7_lo_r) - (BW+1)'(s7_a1_r);
    s8_side_nxt = '{ok: s7_ok_r && !s8_tiny, xdom: s7_xdom_r,
                    a0: s8_dir ? s7_lo_r : s7_hi_r,
                    a1: s8_dir ? s7_hi_r : s7_lo_r,
                    b0: s7_b0_r, b1: s7_b1_r, clo: s7_clo_r, chi: s7_chi_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_side_r <= s8_side_nxt;
      s8_da_r   <= (CW+1)'(s7_a1_r) - (CW+1)'(s7_a0_r);
      s8_db_r   <= (CW+1)'(s7_b1_r) - (CW+1)'(s7_b0_r);
      s8_n20_r  <= s8_n20_nxt;
      s8_n21_r  <= s8_n21_nxt;
    end
  end

  lrc_scale u_str0 (
    .clk (clk),
    .en  (adv),
    .n1  (N1W'(s8_db_r)),
    .n2  (N2W'(s8_n20_r)),
    .d   (DW'(s8_da_r)),
    .q   (q0)
  );

  lrc_scale u_str1 (
    .clk (clk),
    .en  (adv),
    .n1  (N1W'(s8_db_r)),
    .n2  (N2W'(s8_n21_r)),
    .d   (DW'(s8_da_r)),
    .q   (q1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1_r[0] <= s8_side_r;
      for (int k = 1; k < SCL_LAT; k++) begin
        dl1_r[k] <= dl1_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_side_r <= dl1_r[SCL_LAT-1];
      s9_b0_r   <= sat48((PW+1)'(dl1_r[SCL_LAT-1].b0) + (PW+1)'(q0));
      s9_b1_r   <= sat48((PW+1)'(dl1_r[SCL_LAT-1].b1) + (PW+1)'(q1));
    end
  end

  always_comb begin
    c_lo   = PW'(s9_side_r.clo);
    c_hi   = PW'(s9_side_r.chi);
    c_a0   = s9_b0_r;
    c_a1   = s9_b1_r;
    c_rej  = (c_a0 <= c_lo && c_a1 <= c_lo) || (c_a0 >= c_hi && c_a1 >= c_hi);
    c_dir  = c_a1 > c_a0;
    c_tiny = (c_a1 == c_a0) || ((c_a1 < c_a0 + EPS_P) && (c_a1 > c_a0 - EPS_P));
    s10_n20_nxt = (PW+1)'(c_dir ? c_lo : c_hi) - (PW+1)'(c_a0);
    s10_n21_nxt = (PW+1)'(c_dir ? c_hi : c_lo) - (PW+1)'(c_a1);
    s10_side_nxt = '{ok: s9_side_r.ok && !c_rej, xdom: s9_side_r.xdom,
                     a0: c_a0, a1: c_a1,
                     b0: s9_side_r.a0, b1: s9_side_r.a1,
                     mv0: !c_tiny && (c_dir ? (c_a0 < c_lo) : (c_a0 > c_hi)),
                     mv1: !c_tiny && (c_dir ? (c_a1 > c_hi) : (c_a1 < c_lo)),
                     t0: c_dir ? s9_side_r.clo : s9_side_r.chi,
                     t1: c_dir ? s9_side_r.chi : s9_side_r.clo};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_side_r <= s10_side_nxt;
      s10_da_r   <= (PW+1)'(c_a1) - (PW+1)'(c_a0);
      s10_db_r   <= (BW+1)'(s9_side_r.a1) - (BW+1)'(s9_side_r.a0);
      s10_n20_r  <= s10_n20_nxt;
      s10_n21_r  <= s10_n21_nxt;
    end
  end

  lrc_scale u_cut0 (
    .clk (clk),
    .en  (adv),
    .n1  (N1W'(s10_db_r)),
    .n2  (N2W'(s10_n20_r)),
    .d   (DW'(s10_da_r)),
    .q   (q2)
  );

  lrc_scale u_cut1 (
    .clk (clk),
    .en  (adv),
    .n1  (N1W'(s10_db_r)),
    .n2  (N2W'(s10_n21_r)),
    .d   (DW'(s10_da_r)),
    .q   (q3)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_r[0] <= s10_side_r;
      for (int k = 1; k < SCL_LAT; k++) begin
        dl2_r[k] <= dl2_r[k-1];
      end
    end
  end

  assign dl2_o = dl2_r[SCL_LAT-1];

  always_comb begin
    c_a0n = dl2_o.mv0 ? PW'(dl2_o.t0) : dl2_o.a0;
    c_a1n = dl2_o.mv1 ? PW'(dl2_o.t1) : dl2_o.a1;
    c_b0n = dl2_o.mv0 ? sat48((PW+1)'(dl2_o.b0) + (PW+1)'(q2)) : PW'(dl2_o.b0);
    c_b1n = dl2_o.mv1 ? sat48((PW+1)'(dl2_o.b1) + (PW+1)'(q3)) : PW'(dl2_o.b1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_ok_r <= dl2_o.ok;
      s11_x0_r <= dl2_o.xdom ? c_b0n : c_a0n;
      s11_y0_r <= dl2_o.xdom ? c_a0n : c_b0n;
      s11_x1_r <= dl2_o.xdom ? c_b1n : c_a1n;
      s11_y1_r <= dl2_o.xdom ? c_a1n : c_b1n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_visible_r <= s11_ok_r;
      out_sx_r      <= s11_ok_r ? sat32(s11_x0_r) : '0;
      out_sy_r      <= s11_ok_r ? sat32(s11_y0_r) : '0;
      out_ex_r      <= s11_ok_r ? sat32(s11_x1_r) : '0;
      out_ey_r      <= s11_ok_r ? sat32(s11_y1_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = out_visible_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;

`ifndef SYNTHESIS
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_clip_start_x == 0 && out_clip_start_y == 0 &&
                                  out_clip_end_x == 0 && out_clip_end_y == 0)
    else $error("hidden result carries nonzero coordinates");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output is held");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_v_r)
    else $error("accepted transaction missing from first stage");
`endif

endmodule

// ----- test/lrc_checker.sv -----
// Checker for the line/ray/segment rectangle clipper: tracks the rectangle
// writes, predicts each clip result and compares it with the output channel.
// Depends on lrc_pkg (coordinate width and epsilon) from the RTL.
package lrc_tb_pkg;
  typedef enum logic [1:0] {REG_LEFT, REG_BOTTOM, REG_RIGHT, REG_TOP} rect_reg_e;
  typedef enum logic [1:0] {OP_LINE, OP_RAY, OP_SEGMENT, OP_UNUSED} clip_op_e;
endpackage

module lrc_checker
  import lrc_pkg::*;
  import lrc_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic signed [CW-1:0] in_start_x,
  input  logic signed [CW-1:0] in_start_y,
  input  logic signed [CW-1:0] in_end_x,
  input  logic signed [CW-1:0] in_end_y,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_visible,
  input  logic signed [CW-1:0] out_clip_start_x,
  input  logic signed [CW-1:0] out_clip_start_y,
  input  logic signed [CW-1:0] out_clip_end_x,
  input  logic signed [CW-1:0] out_clip_end_y,
  output int                   errors,
  output int                   pending,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint EPS = EPSILON_LSB;
  localparam longint SAT = longint'(1) << 48;

  typedef struct {
    longint x0, y0, x1, y1;
  } box_t;

  typedef struct {
    logic          visible;
    logic [CW-1:0] c[4];
  } clip_t;

  clip_t  clip_q[$];
  longint rect_l, rect_b, rect_r, rect_t;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint sat48(longint v);
    if (v > SAT) return SAT;
    if (v < -SAT) return -SAT;
    return v;
  endfunction

  function automatic longint lerp(longint n1, longint n2, longint d);
    logic [127:0] prod, q;
    bit           neg;
    neg  = ((n1 < 0) != (n2 < 0)) != (d < 0);
    prod = 128'(mag(n1)) * 128'(mag(n2));
    q    = prod / 128'(mag(d));
    if (q > 128'(SAT)) q = 128'(SAT);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic bit box_empty(box_t b);
    return (b.x0 == b.x1 && b.y0 == b.y1) || b.x0 > b.x1 || b.y0 > b.y1;
  endfunction

  function automatic bit tiny(longint d);
    return d == 0 || mag(d) < longint'(EPS);
  endfunction

  function automatic bit stretch(inout longint a0, inout longint b0, inout longint a1,
                                 inout longint b1, input longint lo, input longint hi);
    longint da, db;
    da = a1 - a0;
    db = b1 - b0;
    if (tiny(da)) return 0;
    if (da > 0) begin
      b0 = sat48(b0 + lerp(db, lo - a0, da)); a0 = lo;
      b1 = sat48(b1 + lerp(db, hi - a1, da)); a1 = hi;
    end else begin
      b0 = sat48(b0 + lerp(db, hi - a0, da)); a0 = hi;
      b1 = sat48(b1 + lerp(db, lo - a1, da)); a1 = lo;
    end
    return 1;
  endfunction

  function automatic bit cut(inout longint a0, inout longint b0, inout longint a1,
                             inout longint b1, input longint lo, input longint hi);
    longint da, db;
    if (a0 <= lo && a1 <= lo) return 0;
    if (a0 >= hi && a1 >= hi) return 0;
    da = a1 - a0;
    db = b1 - b0;
    if (tiny(da)) return 1;
    if (da > 0) begin
      if (a0 < lo) begin b0 = sat48(b0 + lerp(db, lo - a0, da)); a0 = lo; end
      if (a1 > hi) begin b1 = sat48(b1 + lerp(db, hi - a1, da)); a1 = hi; end
    end else begin
      if (a0 > hi) begin b0 = sat48(b0 + lerp(db, hi - a0, da)); a0 = hi; end
      if (a1 < lo) begin b1 = sat48(b1 + lerp(db, lo - a1, da)); a1 = lo; end
    end
    return 1;
  endfunction

  function automatic bit clip_to_box(box_t b, inout longint p[4]);
    logic [127:0] wx, wy;
    if (box_empty(b)) return 0;
    wx = 128'(mag(p[0] - p[2])) * 128'(b.y1 - b.y0);
    wy = 128'(mag(p[1] - p[3])) * 128'(b.x1 - b.x0);
    if (wx > wy) begin
      if (!stretch(p[0], p[1], p[2], p[3], b.x0, b.x1)) return 0;
      return cut(p[1], p[0], p[3], p[2], b.y0, b.y1);
    end
    if (!stretch(p[1], p[0], p[3], p[2], b.y0, b.y1)) return 0;
    return cut(p[0], p[1], p[2], p[3], b.x0, b.x1);
  endfunction

  function automatic logic [CW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[CW-1:0];
  endfunction

  function automatic clip_t predict_clip(clip_op_e op, longint sx, longint sy,
                                         longint ex, longint ey);
    clip_t  r;
    box_t   b;
    longint p[4];
    bit     ok;
    p = '{sx, sy, ex, ey};
    b = '{rect_l, rect_b, rect_r, rect_t};
    ok = 0;
    case (op)
      OP_LINE: ok = clip_to_box(b, p);
      OP_RAY: begin
        if (!box_empty(b)) begin
          if (p[0] <= p[2]) begin
            if (b.x0 < p[0] - EPS) b.x0 = p[0] - EPS;
          end else if (b.x1 > p[0] + EPS) b.x1 = p[0] + EPS;
          if (p[1] <= p[3]) begin
            if (b.y0 < p[1] - EPS) b.y0 = p[1] - EPS;
          end else if (b.y1 > p[1] + EPS) b.y1 = p[1] + EPS;
          ok = clip_to_box(b, p);
        end
      end
      OP_SEGMENT: begin
        if (((p[0] < p[2]) ? p[0] : p[2]) - EPS > b.x0) b.x0 = ((p[0] < p[2]) ? p[0] : p[2]) - EPS;
        if (((p[1] < p[3]) ? p[1] : p[3]) - EPS > b.y0) b.y0 = ((p[1] < p[3]) ? p[1] : p[3]) - EPS;
        if (((p[0] > p[2]) ? p[0] : p[2]) + EPS < b.x1) b.x1 = ((p[0] > p[2]) ? p[0] : p[2]) + EPS;
        if (((p[1] > p[3]) ? p[1] : p[3]) + EPS < b.y1) b.y1 = ((p[1] > p[3]) ? p[1] : p[3]) + EPS;
        ok = clip_to_box(b, p);
      end
      default: ok = 0;
    endcase
    r.visible = ok;
    for (int i = 0; i < 4; i++) r.c[i] = ok ? clamp32(p[i]) : '0;
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    clip_t want;
    if (!rst_n) begin
      rect_l <= -65536;
      rect_b <= -65536;
      rect_r <= 65536;
      rect_t <= 65536;
      clip_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (in_valid && !in_stall) begin
        clip_q.push_back(predict_clip(clip_op_e'(in_op), in_start_x, in_start_y,
                                      in_end_x, in_end_y));
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (clip_q.size() == 0) begin
          report("unexpected transaction, visible", 0, out_visible);
        end else begin
          want = clip_q.pop_front();
          if (out_visible !== want.visible) report("visible", want.visible, out_visible);
          if (out_clip_start_x !== want.c[0]) report("clip_start_x", want.c[0], out_clip_start_x);
          if (out_clip_start_y !== want.c[1]) report("clip_start_y", want.c[1], out_clip_start_y);
          if (out_clip_end_x !== want.c[2]) report("clip_end_x", want.c[2], out_clip_end_x);
          if (out_clip_end_y !== want.c[3]) report("clip_end_y", want.c[3], out_clip_end_y);
        end
      end
      if (cfg_we) begin
        case (rect_reg_e'(cfg_index))
          REG_LEFT:   rect_l <= longint'(signed'(cfg_data));
          REG_BOTTOM: rect_b <= longint'(signed'(cfg_data));
          REG_RIGHT:  rect_r <= longint'(signed'(cfg_data));
          REG_TOP:    rect_t <= longint'(signed'(cfg_data));
        endcase
      end
    end
    pending = clip_q.size();
  end
endmodule

// ----- test/tb_line_ray_segment_rect_clip.sv -----
// Testbench top for line_ray_segment_rect_clip: drives directed and random
// clip transactions under several rectangles and gives the verdict.
// Depends on lrc_pkg, lrc_tb_pkg and lrc_checker.
module tb_line_ray_segment_rect_clip;
  import lrc_pkg::*;
  import lrc_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_RECT = 172;
  localparam int QUIET_LIMIT    = 5000;
  localparam longint MAX32      = 64'sd2147483647;
  localparam longint MIN32      = -64'sd2147483648;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CW-1:0]        cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_op;
  logic signed [CW-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_visible;
  logic signed [CW-1:0] out_clip_start_x, out_clip_start_y, out_clip_end_x, out_clip_end_y;
  int                   errors, pending, checked;

  int     tx_idle, rx_idle;
  int     n_sent, n_rects, quiet;
  bit     held;
  longint cur_l, cur_b, cur_r, cur_t;

  line_ray_segment_rect_clip i_dut (.*);

  lrc_checker i_checker (.*);

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stall, plus one long hold-off that backs up into the sender
  always @(posedge clk) begin
    int hold;
    if (!held && n_sent >= 300) begin
      held = 1;
      hold = 400;
    end
    if (hold > 0) begin
      out_stall <= 1;
      hold--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("line_ray_segment_rect_clip: mismatch");
      $finish;
    end
  end

  function automatic logic [CW-1:0] clamp32(longint v);
    if (v > MAX32) v = MAX32;
    if (v < MIN32) v = MIN32;
    return v[CW-1:0];
  endfunction

  function automatic longint pick_coord(longint lo, longint hi);
    longint          span;
    longint unsigned r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1: return longint'(signed'($urandom));
      2: return $urandom_range(1) ? MAX32 : MIN32;
      3: return lo + $urandom_range(4) - 2;
      4: return hi + $urandom_range(4) - 2;
      default: begin
        span = hi - lo;
        if (span < 0) span = -span;
        if (span < 8) span = 8;
        return lo - span / 2 + longint'(r % longint'(2 * span));
      end
    endcase
  endfunction

  task automatic send(clip_op_e op, longint sx, longint sy, longint ex, longint ey);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid   <= 1;
    in_op      <= op;
    in_start_x <= clamp32(sx);
    in_start_y <= clamp32(sy);
    in_end_x   <= clamp32(ex);
    in_end_y   <= clamp32(ey);
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic send_random();
    clip_op_e op;
    longint   sx, sy, ex, ey;
    op = ($urandom_range(19) == 0) ? OP_UNUSED : clip_op_e'($urandom_range(2));
    sx = pick_coord(cur_l, cur_r);
    sy = pick_coord(cur_b, cur_t);
    if ($urandom_range(3) == 0) begin
      ex = sx + $urandom_range(6) - 3;
      ey = sy + $urandom_range(6) - 3;
    end else begin
      ex = pick_coord(cur_l, cur_r);
      ey = pick_coord(cur_b, cur_t);
    end
    send(op, sx, sy, ex, ey);
  endtask

  task automatic set_rect(longint l, longint b, longint r, longint t);
    wait (pending == 0);
    repeat (130) @(posedge clk);
    cur_l = l; cur_b = b; cur_r = r; cur_t = t;
    cfg_we <= 1;
    cfg_index <= REG_LEFT;   cfg_data <= clamp32(l); @(posedge clk);
    cfg_index <= REG_BOTTOM; cfg_data <= clamp32(b); @(posedge clk);
    cfg_index <= REG_RIGHT;  cfg_data <= clamp32(r); @(posedge clk);
    cfg_index <= REG_TOP;    cfg_data <= clamp32(t); @(posedge clk);
    cfg_we <= 0;
    n_rects++;
  endtask

  initial begin
    longint l, b;
    rst_n      <= 0;
    cfg_we     <= 0;
    cfg_index  <= REG_LEFT;
    cfg_data   <= '0;
    in_valid   <= 0;
    in_op      <= OP_LINE;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x   <= '0;
    in_end_y   <= '0;
    out_stall  <= 0;
    tx_idle = 0; rx_idle = 0;
    n_sent = 0; n_rects = 1; held = 0; quiet = 0;
    cur_l = -65536; cur_b = -65536; cur_r = 65536; cur_t = 65536;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(OP_LINE, -131072, 0, 131072, 32768);
    send(OP_LINE, 0, -131072, 16384, 131072);
    send(OP_LINE, 5, 5, 5, 5);
    send(OP_LINE, MIN32, MIN32, MAX32, MAX32);
    send(OP_LINE, MIN32, MAX32, MAX32, MIN32);
    send(OP_LINE, 0, 196608, 65536, 196609);
    send(OP_LINE, 65536, 0, 65536, 65536);
    send(OP_LINE, -200000, 65536, 200000, 65536);
    send(OP_RAY, 0, 0, 65536, 32768);
    send(OP_RAY, 0, 0, -65536, -32768);
    send(OP_RAY, 131072, 0, 196608, 0);
    send(OP_RAY, MAX32, MIN32, MIN32, MAX32);
    send(OP_RAY, 7, 7, 7, 7);
    send(OP_SEGMENT, -32768, -32768, 32768, 16384);
    send(OP_SEGMENT, 1000, 1000, 1000, 1000);
    send(OP_SEGMENT, 100000, 0, 200000, 1);
    send(OP_SEGMENT, MIN32, 0, MAX32, 0);
    send(OP_SEGMENT, 0, 0, 0, 1);
    send(OP_SEGMENT, -65536, -65536, 65536, 65536);
    send(OP_UNUSED, 0, 0, 65536, 65536);
    send(OP_UNUSED, MIN32, MAX32, MAX32, MIN32);
    in_valid <= 0;

    for (int k = 0; k < 9; k++) begin
      case (k / 3)
        0: begin tx_idle = 13; rx_idle = 46; end
        1: begin tx_idle = 46; rx_idle = 13; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      case (k)
        0: ;
        1: set_rect(MIN32, MIN32, MAX32, MAX32);
        2: set_rect(-3, -2, 4, 1);
        4: set_rect(65536, 0, -65536, 65536);
        5: set_rect(1234, -77, 1234, -77);
        6: set_rect(0, -65536, 0, 65536);
        default: begin
          l = longint'(signed'($urandom)) >>> $urandom_range(16);
          b = longint'(signed'($urandom)) >>> $urandom_range(16);
          set_rect(l, b, l + $urandom_range(1 << 20), b + $urandom_range(1 << 20));
        end
      endcase
      repeat (ITEMS_PER_RECT) send_random();
      in_valid <= 0;
    end

    wait (pending == 0);
    repeat (150) @(posedge clk);
    $display("covered %0d transactions (%0d checked) over %0d rectangles", n_sent, checked,
             n_rects);
    $display("lines, rays, segments and the unused op, with both sides stalling");
    if (errors == 0) begin
      $display("line_ray_segment_rect_clip: match");
    end else begin
      $display("line_ray_segment_rect_clip: mismatch");
    end
    $finish;
  end
endmodule
